// ===== rtl/qppw_pkg.sv =====
// ============================================================================
// qppw_pkg: shared types and microcode for the quad perspective point warp
// Holds the operation codes, the unit interface structs, the register file
// map and the constant microcode store run by the sequencer.
// ============================================================================
`default_nettype none

package qppw_pkg;

  localparam int RfAddrW  = 6;
  localparam int RfDepth  = 1 << RfAddrW;
  localparam int PcW      = 8;
  localparam int RomDepth = 1 << PcW;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIVM,
    OP_DIVP,
    OP_MST,
    OP_LDX,
    OP_LDY,
    OP_LDONE,
    OP_LDPX,
    OP_LDPY,
    OP_ENDM,
    OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    AL_IDLE,
    AL_MUL,
    AL_MRND,
    AL_DIV,
    AL_DRND
  } alu_state_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_FETCH,
    SQ_EXEC,
    SQ_WAIT
  } seq_state_e;

  typedef struct packed {
    logic start;
    op_e  op;
    logic bad;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic zdiv;
  } alu_rsp_t;

  typedef struct packed {
    op_e                op;
    logic [RfAddrW-1:0] dst;
    logic [RfAddrW-1:0] a;
    logic [RfAddrW-1:0] b;
  } uinstr_t;

  typedef uinstr_t [RomDepth-1:0] urom_t;

  // Register file map. Each quad owns a block of sixteen entries.
  localparam logic [RfAddrW-1:0] RDX1 = 6'd32;
  localparam logic [RfAddrW-1:0] RDY1 = 6'd33;
  localparam logic [RfAddrW-1:0] RDX2 = 6'd34;
  localparam logic [RfAddrW-1:0] RDY2 = 6'd35;
  localparam logic [RfAddrW-1:0] RSX  = 6'd36;
  localparam logic [RfAddrW-1:0] RSY  = 6'd37;
  localparam logic [RfAddrW-1:0] RDEN = 6'd38;
  localparam logic [RfAddrW-1:0] RT1  = 6'd39;
  localparam logic [RfAddrW-1:0] RT2  = 6'd40;
  localparam logic [RfAddrW-1:0] RONE = 6'd41;
  localparam int                 RC   = 42;
  localparam logic [RfAddrW-1:0] RDET = 6'd51;
  localparam int                 RW   = 52;
  localparam logic [RfAddrW-1:0] RPX  = 6'd61;
  localparam logic [RfAddrW-1:0] RPY  = 6'd62;
  localparam int                 RV   = 32;

  localparam logic [PcW-1:0] RecompPc = 8'd17;

  function automatic uinstr_t mk(op_e op, int d, int a, int b);
    uinstr_t u;
    u.op  = op;
    u.dst = RfAddrW'(d);
    u.a   = RfAddrW'(a);
    u.b   = RfAddrW'(b);
    return u;
  endfunction

  // Entry k of the unit-square-to-quad matrix of quad q.
  function automatic int qs(int q, int k);
    int r;
    case (k)
      0:       r = 16 * q + 10;
      1:       r = 16 * q + 11;
      2:       r = 16 * q;
      3:       r = 16 * q + 12;
      4:       r = 16 * q + 13;
      5:       r = 16 * q + 4;
      6:       r = 16 * q + 8;
      7:       r = 16 * q + 9;
      default: r = int'(RONE);
    endcase
    return r;
  endfunction

  function automatic urom_t build_urom();
    urom_t r;
    int    n;
    int    b;
    int    i;
    int    j;
    int    q;
    int    k;
    for (n = 0; n < RomDepth; n++) r[n] = mk(OP_DONE, 0, 0, 0);
    n = 0;
    // Point program.
    r[n] = mk(OP_LDPX, RPX, 0, 0); n++;
    r[n] = mk(OP_LDPY, RPY, 1, 0); n++;
    for (i = 0; i < 3; i++) begin
      r[n] = mk(OP_MUL, RT1, RPX, RW + 3 * i); n++;
      r[n] = mk(OP_MUL, RT2, RPY, RW + 3 * i + 1); n++;
      r[n] = mk(OP_ADD, RT1, RT1, RT2); n++;
      r[n] = mk(OP_ADD, RV + i, RT1, RW + 3 * i + 2); n++;
    end
    r[n] = mk(OP_DIVP, 0, RV, RV + 2); n++;
    r[n] = mk(OP_DIVP, 1, RV + 1, RV + 2); n++;
    r[n] = mk(OP_DONE, 0, 0, 0); n++;
    // Matrix rebuild, falling back into the point program at its end.
    r[n] = mk(OP_LDONE, RONE, 0, 0); n++;
    for (q = 0; q < 2; q++) begin
      b = 16 * q;
      for (k = 0; k < 4; k++) begin
        r[n] = mk(OP_LDX, b + k, 4 * q + k, 0); n++;
      end
      for (k = 0; k < 4; k++) begin
        r[n] = mk(OP_LDY, b + 4 + k, 4 * q + k, 0); n++;
      end
      r[n] = mk(OP_SUB, RDX1, b + 1, b + 2); n++;
      r[n] = mk(OP_SUB, RDY1, b + 5, b + 6); n++;
      r[n] = mk(OP_SUB, RDX2, b + 3, b + 2); n++;
      r[n] = mk(OP_SUB, RDY2, b + 7, b + 6); n++;
      r[n] = mk(OP_SUB, RSX, b, b + 1); n++;
      r[n] = mk(OP_ADD, RSX, RSX, b + 2); n++;
      r[n] = mk(OP_SUB, RSX, RSX, b + 3); n++;
      r[n] = mk(OP_SUB, RSY, b + 4, b + 5); n++;
      r[n] = mk(OP_ADD, RSY, RSY, b + 6); n++;
      r[n] = mk(OP_SUB, RSY, RSY, b + 7); n++;
      r[n] = mk(OP_MUL, RT1, RDX1, RDY2); n++;
      r[n] = mk(OP_MUL, RT2, RDX2, RDY1); n++;
      r[n] = mk(OP_SUB, RDEN, RT1, RT2); n++;
      r[n] = mk(OP_MUL, RT1, RSX, RDY2); n++;
      r[n] = mk(OP_MUL, RT2, RDX2, RSY); n++;
      r[n] = mk(OP_SUB, RT1, RT1, RT2); n++;
      r[n] = mk(OP_DIVM, b + 8, RT1, RDEN); n++;
      r[n] = mk(OP_MUL, RT1, RDX1, RSY); n++;
      r[n] = mk(OP_MUL, RT2, RSX, RDY1); n++;
      r[n] = mk(OP_SUB, RT1, RT1, RT2); n++;
      r[n] = mk(OP_DIVM, b + 9, RT1, RDEN); n++;
      r[n] = mk(OP_SUB, RT1, b + 1, b); n++;
      r[n] = mk(OP_MUL, RT2, b + 8, b + 1); n++;
      r[n] = mk(OP_ADD, b + 10, RT1, RT2); n++;
      r[n] = mk(OP_SUB, RT1, b + 3, b); n++;
      r[n] = mk(OP_MUL, RT2, b + 9, b + 3); n++;
      r[n] = mk(OP_ADD, b + 11, RT1, RT2); n++;
      r[n] = mk(OP_SUB, RT1, b + 5, b + 4); n++;
      r[n] = mk(OP_MUL, RT2, b + 8, b + 5); n++;
      r[n] = mk(OP_ADD, b + 12, RT1, RT2); n++;
      r[n] = mk(OP_SUB, RT1, b + 7, b + 4); n++;
      r[n] = mk(OP_MUL, RT2, b + 9, b + 7); n++;
      r[n] = mk(OP_ADD, b + 13, RT1, RT2); n++;
    end
    // Adjugate of the source matrix.
    r[n] = mk(OP_MUL, RT1, qs(0, 5), qs(0, 7)); n++;
    r[n] = mk(OP_SUB, RC + 0, qs(0, 4), RT1); n++;
    r[n] = mk(OP_MUL, RT1, qs(0, 2), qs(0, 7)); n++;
    r[n] = mk(OP_SUB, RC + 1, RT1, qs(0, 1)); n++;
    r[n] = mk(OP_MUL, RT1, qs(0, 1), qs(0, 5)); n++;
    r[n] = mk(OP_MUL, RT2, qs(0, 2), qs(0, 4)); n++;
    r[n] = mk(OP_SUB, RC + 2, RT1, RT2); n++;
    r[n] = mk(OP_MUL, RT1, qs(0, 5), qs(0, 6)); n++;
    r[n] = mk(OP_SUB, RC + 3, RT1, qs(0, 3)); n++;
    r[n] = mk(OP_MUL, RT1, qs(0, 2), qs(0, 6)); n++;
    r[n] = mk(OP_SUB, RC + 4, qs(0, 0), RT1); n++;
    r[n] = mk(OP_MUL, RT1, qs(0, 2), qs(0, 3)); n++;
    r[n] = mk(OP_MUL, RT2, qs(0, 0), qs(0, 5)); n++;
    r[n] = mk(OP_SUB, RC + 5, RT1, RT2); n++;
    r[n] = mk(OP_MUL, RT1, qs(0, 3), qs(0, 7)); n++;
    r[n] = mk(OP_MUL, RT2, qs(0, 4), qs(0, 6)); n++;
    r[n] = mk(OP_SUB, RC + 6, RT1, RT2); n++;
    r[n] = mk(OP_MUL, RT1, qs(0, 1), qs(0, 6)); n++;
    r[n] = mk(OP_MUL, RT2, qs(0, 0), qs(0, 7)); n++;
    r[n] = mk(OP_SUB, RC + 7, RT1, RT2); n++;
    r[n] = mk(OP_MUL, RT1, qs(0, 0), qs(0, 4)); n++;
    r[n] = mk(OP_MUL, RT2, qs(0, 1), qs(0, 3)); n++;
    r[n] = mk(OP_SUB, RC + 8, RT1, RT2); n++;
    // Determinant, then the inverse in place of the adjugate.
    r[n] = mk(OP_MUL, RT1, qs(0, 0), RC + 0); n++;
    r[n] = mk(OP_MUL, RT2, qs(0, 1), RC + 3); n++;
    r[n] = mk(OP_ADD, RT1, RT1, RT2); n++;
    r[n] = mk(OP_MUL, RT2, qs(0, 2), RC + 6); n++;
    r[n] = mk(OP_ADD, RDET, RT1, RT2); n++;
    for (k = 0; k < 9; k++) begin
      r[n] = mk(OP_DIVM, RC + k, RC + k, RDET); n++;
    end
    // Destination matrix times the inverse.
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        r[n] = mk(OP_MUL, RT1, qs(1, 3 * i), RC + j); n++;
        r[n] = mk(OP_MUL, RT2, qs(1, 3 * i + 1), RC + 3 + j); n++;
        r[n] = mk(OP_ADD, RT1, RT1, RT2); n++;
        r[n] = mk(OP_MUL, RT2, qs(1, 3 * i + 2), RC + 6 + j); n++;
        r[n] = mk(OP_ADD, RT1, RT1, RT2); n++;
        r[n] = mk(OP_MST, RW + 3 * i + j, RT1, 0); n++;
      end
    end
    r[n] = mk(OP_ENDM, 0, 0, 0);
    return r;
  endfunction

  localparam urom_t UROM = build_urom();

endpackage

`default_nettype wire

// ===== rtl/qppw_regfile.sv =====
// ============================================================================
// qppw_regfile: working register file
// One write port and two read ports with registered read data.
// ============================================================================
`default_nettype none

module qppw_regfile
  import qppw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [RfAddrW-1:0] waddr_i,
  input  wire logic [63:0]        wdata_i,
  input  wire logic [RfAddrW-1:0] raddr_a_i,
  input  wire logic [RfAddrW-1:0] raddr_b_i,
  output logic      [63:0]        rdata_a_o,
  output logic      [63:0]        rdata_b_o
);

  logic [63:0] mem_q [RfDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== rtl/qppw_alu.sv =====
// ============================================================================
// qppw_alu: shared arithmetic unit
// Saturating add and subtract, a rounded fixed-point multiply built from four
// 32x32 partial products, a bit-serial rounded divide and a matrix-store clamp.
// ============================================================================
`default_nettype none

module qppw_alu
  import qppw_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire alu_req_t    req_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output alu_rsp_t         rsp_o,
  output logic      [63:0] res_o
);

  localparam int MatFrac = FRAC_BITS + 16;
  localparam logic [63:0] I64Max = {1'b0, {63{1'b1}}};
  localparam logic [63:0] MatMax = 64'(1) << 47;

  alu_state_e   state_q, state_d;
  logic [63:0]  ua_q, ua_d, ub_q, ub_d, rem_q, rem_d, res_q, res_d;
  logic [127:0] acc_q, acc_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         neg_q, neg_d, divp_q, divp_d;
  logic         done_q, done_d, zdiv_q, zdiv_d;

  logic [63:0]  ma, mb, sum, diff, mst, zsat;
  logic         is_div, sum_ovf, diff_ovf;
  logic [63:0]  pp;
  logic [127:0] pp_sh, mq, dq;
  logic [64:0]  rem_sh;
  logic         ge, rup;
  logic [63:0]  mmag, dmag, msres, dsres, dres;

  assign ma = a_i[63] ? 64'd0 - a_i : a_i;
  assign mb = b_i[63] ? 64'd0 - b_i : b_i;
  assign is_div = (req_i.op == OP_DIVM) || (req_i.op == OP_DIVP);

  assign sum      = a_i + b_i;
  assign sum_ovf  = (a_i[63] == b_i[63]) && (sum[63] != a_i[63]);
  assign diff     = a_i - b_i;
  assign diff_ovf = (a_i[63] != b_i[63]) && (diff[63] != a_i[63]);

  always_comb begin
    if (req_i.bad) begin
      mst = '0;
    end else if ($signed(a_i) >= $signed(MatMax)) begin
      mst = MatMax - 64'd1;
    end else if ($signed(a_i) < -$signed(MatMax)) begin
      mst = 64'd0 - MatMax;
    end else begin
      mst = a_i;
    end
  end

  // A zero divisor on a point saturates toward the sign of the numerator.
  always_comb begin
    if (a_i[63]) begin
      zsat = 64'hFFFF_FFFF_8000_0000;
    end else if (a_i != 64'd0) begin
      zsat = 64'h0000_0000_7FFF_FFFF;
    end else begin
      zsat = '0;
    end
  end

  assign pp = 64'(cnt_q[1] ? ua_q[63:32] : ua_q[31:0])
            * 64'(cnt_q[0] ? ub_q[63:32] : ub_q[31:0]);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
  end

  assign mq    = (acc_q + (128'(1) << (MatFrac - 1))) >> MatFrac;
  assign mmag  = (|mq[127:63]) ? I64Max : mq[63:0];
  assign msres = neg_q ? 64'd0 - mmag : mmag;

  assign rem_sh = {rem_q, acc_q[127]};
  assign ge     = rem_sh >= {1'b0, ub_q};

  assign rup   = {rem_q, 1'b0} >= {1'b0, ub_q};
  assign dq    = acc_q + 128'(rup);
  assign dmag  = (|dq[127:63]) ? I64Max : dq[63:0];
  assign dsres = neg_q ? 64'd0 - dmag : dmag;

  always_comb begin
    if (!divp_q) begin
      dres = dsres;
    end else if ($signed(dsres) > 64'sd2147483647) begin
      dres = 64'h0000_0000_7FFF_FFFF;
    end else if ($signed(dsres) < -64'sd2147483648) begin
      dres = 64'hFFFF_FFFF_8000_0000;
    end else begin
      dres = dsres;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      AL_IDLE: begin
        if (req_i.start && (req_i.op == OP_MUL)) begin
          state_d = AL_MUL;
        end else if (req_i.start && is_div && (mb != 64'd0)) begin
          state_d = AL_DIV;
        end
      end
      AL_MUL: begin
        if (cnt_q[1:0] == 2'd3) begin
          state_d = AL_MRND;
        end
      end
      AL_DIV: begin
        if (cnt_q == 7'd127) begin
          state_d = AL_DRND;
        end
      end
      default: state_d = AL_IDLE;
    endcase
  end

  always_comb begin
    ua_d   = ua_q;
    ub_d   = ub_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    divp_d = divp_q;
    res_d  = res_q;
    done_d = 1'b0;
    zdiv_d = 1'b0;
    case (state_q)
      AL_IDLE: begin
        if (req_i.start) begin
          ua_d   = ma;
          ub_d   = mb;
          rem_d  = '0;
          cnt_d  = '0;
          divp_d = req_i.op == OP_DIVP;
          case (req_i.op)
            OP_ADD: begin
              res_d  = sum_ovf ? (a_i[63] ? ~I64Max : I64Max) : sum;
              done_d = 1'b1;
            end
            OP_SUB: begin
              res_d  = diff_ovf ? (a_i[63] ? ~I64Max : I64Max) : diff;
              done_d = 1'b1;
            end
            OP_MST: begin
              res_d  = mst;
              done_d = 1'b1;
            end
            OP_MUL: begin
              acc_d = '0;
              neg_d = a_i[63] ^ b_i[63];
            end
            OP_DIVM, OP_DIVP: begin
              neg_d = a_i[63] ^ b_i[63];
              acc_d = (req_i.op == OP_DIVP) ? (128'(ma) << FRAC_BITS)
                                            : (128'(ma) << MatFrac);
              if (mb == 64'd0) begin
                res_d  = (req_i.op == OP_DIVP) ? zsat : '0;
                done_d = 1'b1;
                zdiv_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      AL_MUL: begin
        acc_d = acc_q + pp_sh;
        cnt_d = cnt_q + 7'd1;
      end
      AL_MRND: begin
        res_d  = msres;
        done_d = 1'b1;
      end
      AL_DIV: begin
        rem_d = ge ? 64'(rem_sh - {1'b0, ub_q}) : rem_sh[63:0];
        acc_d = {acc_q[126:0], ge};
        cnt_d = cnt_q + 7'd1;
      end
      AL_DRND: begin
        res_d  = dres;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AL_IDLE;
      done_q  <= 1'b0;
      zdiv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      zdiv_q  <= zdiv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q   <= ua_d;
    ub_q   <= ub_d;
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    divp_q <= divp_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zdiv = zdiv_q;
  assign res_o      = res_q;

endmodule

`default_nettype wire

// ===== rtl/quad_perspective_point_warp.sv =====
// ============================================================================
// quad_perspective_point_warp: quad-to-quad perspective point warp
// Maps Q16.16 points through the homography that carries a configured source
// quadrilateral onto a configured destination quadrilateral.
// ============================================================================
//
//  channel   | signals                                       | direction
//  ----------+-----------------------------------------------+----------
//  request   | start, busy, point_x_i, point_y_i             | in/out
//  result    | done_o, warped_x_o, warped_y_o, degenerate_o  | out
//  config    | psel, penable, pwrite, paddr, pwdata, prdata, | in/out
//            | pready (corner i at byte address 8*i)         |
//
// A request is taken when start is high and busy is low. The cost of a point
// is set by the two 128-step divisions by w in the shared unit.
// The first request after any corner write first rebuilds the matrix, whose
// cost is dominated by thirteen more divisions.
// Reset restores the unit-square corners and marks the matrix stale.
// The result is shown for one cycle with done_o; the receiver cannot stall.
//
// A small sequencer steps through a constant microcode store. Each arithmetic
// step reads two operands from the register file, runs them through the
// shared unit and writes the result back, or out for a point divide.
// Divisions by zero in the rebuild mark the matrix degenerate and clear it.
`default_nettype none

module quad_perspective_point_warp
  import qppw_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] point_x_i,
  input  wire logic [31:0] point_y_i,
  output logic             done_o,
  output logic      [31:0] warped_x_o,
  output logic      [31:0] warped_y_o,
  output logic             degenerate_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  localparam int          MatFrac = FRAC_BITS + 16;
  localparam logic [63:0] One     = 64'(1) << FRAC_BITS;

  seq_state_e     sq_q, sq_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic           stale_q, stale_d, mdeg_q, mdeg_d, bad_q, bad_d;
  logic           wzero_q, wzero_d, done_q, done_d, deg_q, deg_d;
  logic [31:0]    wx_q, wx_d, wy_q, wy_d, px_q, py_q;
  logic [63:0]    corner_q [8];

  uinstr_t        instr;
  logic [63:0]    corner_sel, ld_val;
  logic           is_load, is_alu, cfg_wr, accept;
  logic           rf_we;
  logic [RfAddrW-1:0] rf_waddr;
  logic [63:0]    rf_wdata, rd_a, rd_b, alu_res;
  alu_req_t       alu_req;
  alu_rsp_t       alu_rsp;

  assign instr  = UROM[pc_q];
  assign cfg_wr = psel && penable && pwrite;
  assign accept = start && (sq_q == SQ_IDLE);
  assign pready = 1'b1;
  assign prdata = corner_q[paddr[5:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q[0] <= '0;
      corner_q[1] <= One;
      corner_q[2] <= One << 32;
      corner_q[3] <= (One << 32) | One;
      corner_q[4] <= '0;
      corner_q[5] <= One;
      corner_q[6] <= One << 32;
      corner_q[7] <= (One << 32) | One;
    end else if (cfg_wr) begin
      corner_q[paddr[5:3]] <= pwdata;
    end
  end

  assign corner_sel = corner_q[instr.a[2:0]];

  always_comb begin
    case (instr.op)
      OP_LDX:  ld_val = {{16{corner_sel[31]}}, corner_sel[31:0], 16'd0};
      OP_LDY:  ld_val = {{16{corner_sel[63]}}, corner_sel[63:32], 16'd0};
      OP_LDONE: ld_val = 64'(1) << MatFrac;
      OP_LDPX: ld_val = {{16{px_q[31]}}, px_q, 16'd0};
      default: ld_val = {{16{py_q[31]}}, py_q, 16'd0};
    endcase
  end

  assign is_load = (instr.op == OP_LDX) || (instr.op == OP_LDY) ||
                   (instr.op == OP_LDONE) || (instr.op == OP_LDPX) ||
                   (instr.op == OP_LDPY);
  assign is_alu  = !is_load && (instr.op != OP_ENDM) && (instr.op != OP_DONE);

  // Sequencer next state.
  always_comb begin
    sq_d = sq_q;
    case (sq_q)
      SQ_IDLE: begin
        if (start) begin
          sq_d = SQ_FETCH;
        end
      end
      SQ_FETCH: sq_d = SQ_EXEC;
      SQ_EXEC: begin
        if (instr.op == OP_DONE) begin
          sq_d = SQ_IDLE;
        end else if (is_alu) begin
          sq_d = SQ_WAIT;
        end else begin
          sq_d = SQ_FETCH;
        end
      end
      SQ_WAIT: begin
        if (alu_rsp.done) begin
          sq_d = SQ_FETCH;
        end
      end
      default: sq_d = SQ_IDLE;
    endcase
  end

  // Sequencer outputs and flag updates.
  always_comb begin
    pc_d          = pc_q;
    stale_d       = stale_q || cfg_wr;
    mdeg_d        = mdeg_q;
    bad_d         = bad_q;
    wzero_d       = wzero_q;
    done_d        = 1'b0;
    deg_d         = deg_q;
    wx_d          = wx_q;
    wy_d          = wy_q;
    rf_we         = 1'b0;
    rf_waddr      = instr.dst;
    rf_wdata      = alu_res;
    alu_req.start = 1'b0;
    alu_req.op    = instr.op;
    alu_req.bad   = bad_q;
    case (sq_q)
      SQ_IDLE: begin
        if (accept) begin
          pc_d    = stale_q ? RecompPc : '0;
          bad_d   = 1'b0;
          wzero_d = 1'b0;
        end
      end
      SQ_EXEC: begin
        if (is_load) begin
          rf_we    = 1'b1;
          rf_wdata = ld_val;
          pc_d     = pc_q + 1'b1;
        end else if (instr.op == OP_ENDM) begin
          stale_d = 1'b0;
          mdeg_d  = bad_q;
          pc_d    = '0;
        end else if (instr.op == OP_DONE) begin
          done_d = 1'b1;
          deg_d  = mdeg_q || wzero_q;
        end else begin
          alu_req.start = 1'b1;
        end
      end
      SQ_WAIT: begin
        if (alu_rsp.done) begin
          pc_d = pc_q + 1'b1;
          if (instr.op == OP_DIVP) begin
            wzero_d = wzero_q || alu_rsp.zdiv;
            if (instr.dst[0]) begin
              wy_d = alu_res[31:0];
            end else begin
              wx_d = alu_res[31:0];
            end
          end else begin
            rf_we = 1'b1;
            if (instr.op == OP_DIVM) begin
              bad_d = bad_q || alu_rsp.zdiv;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q    <= SQ_IDLE;
      pc_q    <= '0;
      stale_q <= 1'b1;
      mdeg_q  <= 1'b0;
      bad_q   <= 1'b0;
      wzero_q <= 1'b0;
      done_q  <= 1'b0;
      deg_q   <= 1'b0;
    end else begin
      sq_q    <= sq_d;
      pc_q    <= pc_d;
      stale_q <= stale_d;
      mdeg_q  <= mdeg_d;
      bad_q   <= bad_d;
      wzero_q <= wzero_d;
      done_q  <= done_d;
      deg_q   <= deg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wx_q <= wx_d;
    wy_q <= wy_d;
    if (accept) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
  end

  qppw_regfile u_regfile (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata),
    .raddr_a_i (instr.a),
    .raddr_b_i (instr.b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  qppw_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (rd_a),
    .b_i    (rd_b),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  assign busy         = sq_q != SQ_IDLE;
  assign done_o       = done_q;
  assign warped_x_o   = wx_q;
  assign warped_y_o   = wy_q;
  assign degenerate_o = deg_q;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quad perspective point warp testbench
// Programs source and destination corners over the register port, streams
// points through the command handshake and checks every warped point against
// a fixed-point homography predictor kept inside this file.
// ----------------------------------------------------------------------------

module testbench;
  import qppw_pkg::*;

  localparam int  FracBits = 16;
  localparam int  NumRegs  = 8;
  localparam longint OneM  = longint'(1) << (FracBits + 16);
  localparam longint Lift  = 64'sd65536;
  localparam longint MatMax = (longint'(1) <<< 47) - 1;
  localparam longint MatMin = -(longint'(1) <<< 47);
  localparam longint I64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64Min = 64'sh8000_0000_0000_0000;
  localparam longint I32Max = 64'sd2147483647;
  localparam longint I32Min = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
  } point_t;

  typedef struct packed {
    logic [31:0] wx;
    logic [31:0] wy;
    logic        degen;
  } warp_res_t;

  typedef logic [8:0][63:0] mat9_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] point_x_i = '0;
  logic [31:0] point_y_i = '0;
  logic        done_o;
  logic [31:0] warped_x_o;
  logic [31:0] warped_y_o;
  logic        degenerate_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  quad_perspective_point_warp #(.FRAC_BITS(FracBits)) i_dut (
    .clk_i, .rst_ni, .start, .busy, .point_x_i, .point_y_i,
    .done_o, .warped_x_o, .warped_y_o, .degenerate_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  // Mirror of the block's programmable and cached state.
  logic [63:0] corner_q [NumRegs];
  longint      warp_m [9];
  bit          warp_stale;
  bit          warp_degen;

  point_t      pending_points[$];
  warp_res_t   expected_warps[$];
  int unsigned error_count = 0;
  int unsigned points_sent = 0;
  int unsigned degen_seen = 0;
  int unsigned matrix_builds = 0;
  bit          quiet_sender = 1'b0;
  bit          accepted = 1'b0;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the warp datapath.
  // ---------------------------------------------------------------------------

  // round(a*b/d) with ties away from zero, saturated to +-(2^63-1).
  function automatic longint mul_div_round(longint a, longint b, longint d);
    logic [63:0]  ua, ub, ud;
    logic [127:0] prod, quo, rem;
    bit           neg;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    ud = (d < 0) ? 64'(-d) : 64'(d);
    neg = ((a < 0) != (b < 0)) != (d < 0);
    if (ud == 0) return 0;
    prod = {64'd0, ua} * {64'd0, ub};
    quo = prod / {64'd0, ud};
    rem = prod % {64'd0, ud};
    if (rem >= {64'd0, ud} - rem) quo = quo + 1;
    if (quo > 128'h7FFF_FFFF_FFFF_FFFF) quo = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic longint mulq(longint a, longint b);
    return mul_div_round(a, b, OneM);
  endfunction

  function automatic longint clamp65(logic signed [64:0] s);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return I64Max;
    if (s < -65'sh0_8000_0000_0000_0000) return I64Min;
    return longint'(s[63:0]);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return clamp65($signed({a[63], a}) + $signed({b[63], b}));
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    return clamp65($signed({a[63], a}) - $signed({b[63], b}));
  endfunction

  function automatic longint lift32(logic [31:0] v);
    return longint'($signed(v)) * Lift;
  endfunction

  // Unit square onto the quad held at corner registers base..base+3.
  // Returns zero when the corner denominator vanishes.
  function automatic bit square_to_quad(int base, output mat9_t m);
    longint x[4], y[4];
    longint dx1, dy1, dx2, dy2, sx, sy, den, g, h;
    for (int k = 0; k < 4; k++) begin
      x[k] = lift32(corner_q[base + k][31:0]);
      y[k] = lift32(corner_q[base + k][63:32]);
    end
    m = '0;
    dx1 = x[1] - x[2]; dy1 = y[1] - y[2];
    dx2 = x[3] - x[2]; dy2 = y[3] - y[2];
    sx = x[0] - x[1] + x[2] - x[3];
    sy = y[0] - y[1] + y[2] - y[3];
    den = sub_sat(mulq(dx1, dy2), mulq(dx2, dy1));
    if (den == 0) return 1'b0;
    g = mul_div_round(sub_sat(mulq(sx, dy2), mulq(dx2, sy)), OneM, den);
    h = mul_div_round(sub_sat(mulq(dx1, sy), mulq(sx, dy1)), OneM, den);
    m[0] = add_sat(x[1] - x[0], mulq(g, x[1]));
    m[1] = add_sat(x[3] - x[0], mulq(h, x[3]));
    m[2] = x[0];
    m[3] = add_sat(y[1] - y[0], mulq(g, y[1]));
    m[4] = add_sat(y[3] - y[0], mulq(h, y[3]));
    m[5] = y[0];
    m[6] = g;
    m[7] = h;
    m[8] = OneM;
    return 1'b1;
  endfunction

  // Rebuild the cached warp: inverse of the source map, then the
  // destination map multiplied onto it.
  function automatic void rebuild_warp();
    mat9_t  s, d;
    longint cof[9], inv[9];
    longint a, b, c, dd, e, f, g, h, det, acc;
    bit     ok_s, ok_d, ok;
    ok_s = square_to_quad(0, s);
    ok_d = square_to_quad(4, d);
    ok = ok_s && ok_d;
    if (ok) begin
      a = s[0]; b = s[1]; c = s[2]; dd = s[3]; e = s[4];
      f = s[5]; g = s[6]; h = s[7];
      cof[0] = sub_sat(e, mulq(f, h));
      cof[1] = sub_sat(mulq(c, h), b);
      cof[2] = sub_sat(mulq(b, f), mulq(c, e));
      cof[3] = sub_sat(mulq(f, g), dd);
      cof[4] = sub_sat(a, mulq(c, g));
      cof[5] = sub_sat(mulq(c, dd), mulq(a, f));
      cof[6] = sub_sat(mulq(dd, h), mulq(e, g));
      cof[7] = sub_sat(mulq(b, g), mulq(a, h));
      cof[8] = sub_sat(mulq(a, e), mulq(b, dd));
      det = add_sat(add_sat(mulq(a, cof[0]), mulq(b, cof[3])), mulq(c, cof[6]));
      if (det == 0) ok = 1'b0;
      else for (int k = 0; k < 9; k++) inv[k] = mul_div_round(cof[k], OneM, det);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        if (ok)
          for (int k = 0; k < 3; k++)
            acc = add_sat(acc, mulq(longint'(d[i * 3 + k]), inv[k * 3 + j]));
        if (acc > MatMax) acc = MatMax;
        if (acc < MatMin) acc = MatMin;
        warp_m[i * 3 + j] = acc;
      end
    end
    warp_degen = !ok;
    warp_stale = 1'b0;
    matrix_builds++;
  endfunction

  function automatic longint sat32(longint v);
    if (v > I32Max) return I32Max;
    if (v < I32Min) return I32Min;
    return v;
  endfunction

  function automatic warp_res_t warp_point(point_t p);
    longint    px, py, q;
    longint    v[3];
    longint    r[2];
    warp_res_t res;
    if (warp_stale) rebuild_warp();
    px = lift32(p.px);
    py = lift32(p.py);
    for (int k = 0; k < 3; k++)
      v[k] = add_sat(add_sat(mulq(px, warp_m[k * 3]), mulq(py, warp_m[k * 3 + 1])),
                     warp_m[k * 3 + 2]);
    for (int k = 0; k < 2; k++) begin
      // A zero w pushes each coordinate to the rail of its numerator's sign.
      if (v[2] == 0) r[k] = (v[k] > 0) ? I32Max : ((v[k] < 0) ? I32Min : 0);
      else begin
        q = mul_div_round(v[k], longint'(1) << FracBits, v[2]);
        r[k] = sat32(q);
      end
    end
    res.wx = r[0][31:0];
    res.wy = r[1][31:0];
    res.degen = warp_degen || (v[2] == 0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: changes inputs at the falling edge. A request that is
  // still waiting for busy to drop is held as it is.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic   nxt_start;
    point_t p;
    nxt_start = 1'b0;
    p = '{px: point_x_i, py: point_y_i};
    if (rst_ni) begin
      if (start && !accepted) nxt_start = 1'b1;
      else if (pending_points.size() > 0 &&
               (quiet_sender || $urandom_range(0, 99) >= 13)) begin
        p = pending_points.pop_front();
        nxt_start = 1'b1;
      end
    end
    start <= nxt_start;
    point_x_i <= p.px;
    point_y_i <= p.py;
    accepted <= 1'b0;
  end

  // Acceptance and result monitor, sampled at the rising edge.
  always @(posedge clk_i) begin
    warp_res_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_warps.push_back(warp_point('{px: point_x_i, py: point_y_i}));
        points_sent++;
        accepted <= 1'b1;
      end
      if (done_o) begin
        if (degenerate_o) degen_seen++;
        if (expected_warps.size() == 0) begin
          $error("unexpected result x=%h y=%h", warped_x_o, warped_y_o);
          error_count++;
        end else begin
          want = expected_warps.pop_front();
          if (warped_x_o !== want.wx) begin
            $error("warped_x expected %h actual %h", want.wx, warped_x_o);
            error_count++;
          end
          if (warped_y_o !== want.wy) begin
            $error("warped_y expected %h actual %h", want.wy, warped_y_o);
            error_count++;
          end
          if (degenerate_o !== want.degen) begin
            $error("degenerate expected %b actual %b", want.degen, degenerate_o);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Register write: setup cycle, then access cycle.
  task automatic write_corner(int idx, logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 6'(8 * idx);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    corner_q[idx] = value;
    warp_stale = 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [63:0] xy(int x_q, int y_q);
    return {32'(y_q), 32'(x_q)};
  endfunction

  // Waits until every request is taken and every result is back.
  task automatic drain();
    while (pending_points.size() > 0 || start || expected_warps.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 32'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
    if (sel < 90) return $urandom();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // One corner set: mostly a jittered unit square scaled up, sometimes
  // wild values, repeated corners or very large coordinates.
  task automatic program_random_quads();
    int unsigned kind;
    logic [63:0] v;
    int          bx, by;
    for (int i = 0; i < NumRegs; i++) begin
      kind = $urandom_range(0, 99);
      bx = ((i % 4) & 1) ? 32'sh8_0000 : 0;
      by = ((i % 4) & 2) ? 32'sh8_0000 : 0;
      if (kind < 65)
        v = xy(bx + $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000,
               by + $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
      else if (kind < 85) v = {$urandom(), $urandom()};
      else if (kind < 93 && (i % 4) != 0) v = corner_q[i - 1];
      else v = xy(bx * 1024 + $urandom_range(0, 255), by * 1024 - $urandom_range(0, 255));
      write_corner(i, v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    corner_q[0] = xy(0, 0);
    corner_q[1] = xy(32'h1_0000, 0);
    corner_q[2] = xy(0, 32'h1_0000);
    corner_q[3] = xy(32'h1_0000, 32'h1_0000);
    for (int i = 0; i < 4; i++) corner_q[4 + i] = corner_q[i];
    for (int k = 0; k < 9; k++) warp_m[k] = 0;
    warp_stale = 1'b1;
    warp_degen = 1'b0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset corners: identity warp, with field extremes.
    pending_points.push_back('{px: 32'h0001_0000, py: 32'h0002_8000});
    pending_points.push_back('{px: 32'h7FFF_FFFF, py: 32'h8000_0000});
    pending_points.push_back('{px: 32'h8000_0000, py: 32'h7FFF_FFFF});
    pending_points.push_back('{px: 32'h0000_0000, py: 32'hFFFF_FFFF});
    pending_points.push_back('{px: 32'hFFFF_FFFF, py: 32'h0000_0001});
    drain();

    // Kite-shaped destination gives a real perspective divide; points on
    // and near the horizon line drive w toward zero.
    write_corner(4, xy(0, 0));
    write_corner(5, xy(32'h1_0000, 0));
    write_corner(6, xy(0, 32'h1_0000));
    write_corner(7, xy(32'h2_0000, 32'h2_0000));
    pending_points.push_back('{px: 32'h0003_0000, py: 32'h0000_0000});
    pending_points.push_back('{px: 32'h0000_0000, py: 32'h0000_C000});
    pending_points.push_back('{px: 32'h0000_8000, py: 32'h0000_8000});
    pending_points.push_back('{px: 32'hFFFD_0000, py: 32'h0001_8000});
    pending_points.push_back('{px: 32'h7FFF_FFFF, py: 32'h7FFF_FFFF});
    drain();

    // Collapsed source quad: corner denominator vanishes.
    for (int i = 0; i < 4; i++) write_corner(i, xy(32'h1_0000, 32'h1_0000));
    pending_points.push_back('{px: 32'h0001_0000, py: 32'h0001_0000});
    pending_points.push_back('{px: 32'h8000_0000, py: 32'h7FFF_FFFF});
    drain();

    // Collinear source corners that pass the denominator test but leave a
    // singular source map, then register extremes everywhere.
    write_corner(0, xy(0, 0));
    write_corner(1, xy(32'h1_0000, 0));
    write_corner(2, xy(32'h2_0000, 0));
    write_corner(3, xy(32'h3_0000, 32'h1_0000));
    pending_points.push_back('{px: 32'h0001_0000, py: 32'h0000_4000});
    pending_points.push_back('{px: 32'hFFFF_0000, py: 32'h0003_0000});
    drain();
    for (int i = 0; i < NumRegs; i++)
      write_corner(i, (i % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_FFFF_8000_0000);
    pending_points.push_back('{px: 32'h0000_0000, py: 32'h0000_0000});
    pending_points.push_back('{px: 32'h7FFF_FFFF, py: 32'h8000_0000});
    drain();
    for (int i = 0; i < NumRegs; i++)
      write_corner(i, (i % 2) ? 64'h0 : 64'h8000_0000_7FFF_FFFF);
    pending_points.push_back('{px: 32'h0001_0000, py: 32'hFFFF_0000});
    drain();

    // Random phases: new corners each time, random points in between.
    for (int ph = 0; ph < 10; ph++) begin
      program_random_quads();
      quiet_sender = (ph == 4);
      for (int n = 0; n < 188; n++)
        pending_points.push_back('{px: rand_coord(), py: rand_coord()});
      drain();
    end
    quiet_sender = 1'b0;

    repeat (50) @(posedge clk_i);
    if (expected_warps.size() != 0) begin
      $error("%0d results never arrived", expected_warps.size());
      error_count++;
    end
    $display("tb: %0d points warped over %0d matrix builds, %0d flagged degenerate",
             points_sent, matrix_builds, degen_seen);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== quad_perspective_point_warp.f =====
rtl/qppw_pkg.sv
rtl/qppw_regfile.sv
rtl/qppw_alu.sv
rtl/quad_perspective_point_warp.sv
verif/testbench.sv
